>>> hw/rtl/cfe_pkg.sv
// Shared types, codes and default sizes for the categorical frequency estimator.
package cfe_pkg;

  localparam int NUM_ATTRIBUTES_DEF = 8;
  localparam int NUM_CATEGORIES_DEF = 16;
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int PROB_BITS          = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACC   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_SCAN  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] attribute;
    logic [3:0] value;
    logic       row_end;
  } cfe_in_t;

  typedef struct packed {
    logic [PROB_BITS-1:0] probability;
    logic                 zero_found;
    logic [1:0]           status;
  } cfe_out_t;

endpackage

>>> hw/rtl/categorical_frequency_estimator_unit.sv
// Top level of the categorical frequency estimator: count store, sequencer, serial divider.
//
//  channel   direction  handshake          word
//  in        in         in_valid/in_stall   cfe_in_t command
//  out       out        out_valid/out_stall cfe_out_t result
//  cfg       in         cfg_valid/cfg_ready smoothing_enable bit
//
// Clear: one count entry zeroed per cycle.
// Accumulate is a read-modify-write; query runs the one-bit-a-cycle restoring divider
// sharing a single subtractor; scan walks the counts of each attribute in turn.
// After reset the same clearing pass runs, with in_stall high.
// A new word is taken while a result waits on out_stall; it holds in its last step till free.
module categorical_frequency_estimator_unit
  import cfe_pkg::*;
#(
  parameter int NUM_ATTRIBUTES = NUM_ATTRIBUTES_DEF,
  parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  cfe_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cfe_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  localparam int DEPTH = NUM_ATTRIBUTES * NUM_CATEGORIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int AIW   = (NUM_ATTRIBUTES > 1) ? $clog2(NUM_ATTRIBUTES) : 1;
  localparam int CIW   = $clog2(NUM_CATEGORIES);
  localparam int KW    = $clog2(NUM_CATEGORIES + 1);
  localparam int DW    = COUNT_WIDTH + 1;
  localparam int RW    = DW + 1;
  localparam int BCW   = $clog2(PROB_BITS);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_ACC_WR, S_Q_SETUP, S_DIV_CHK, S_DIV,
    S_SCAN_K, S_SCAN_KW, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;

  state_t                 state;
  cfe_in_t                item;
  cfe_out_t               res;
  logic                   clr_reply;
  logic [AW-1:0]          clr_idx;
  logic [COUNT_WIDTH-1:0] instance_count;
  logic                   smoothing_enable;
  logic [RW-1:0]          rem;
  logic [DW-1:0]          den_r;
  logic [BCW-1:0]         bitcnt;
  logic [AIW-1:0]         scan_attr;
  logic [CIW-1:0]         scan_cat;
  logic [KW-1:0]          scan_lim;

  logic [COUNT_WIDTH-1:0] count_mem [DEPTH];
  logic [KW-1:0]          k_mem [NUM_ATTRIBUTES];
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [KW-1:0]          k_q;

  logic                   cnt_we;
  logic [AW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [AW-1:0]          cnt_raddr;
  logic                   k_we;
  logic [AIW-1:0]         k_waddr;
  logic [KW-1:0]          k_wdata;
  logic [AIW-1:0]         k_raddr;

  logic [AW-1:0]          item_addr;
  logic [AW-1:0]          scan_addr;
  logic [AIW-1:0]         attr_idx;
  logic [KW-1:0]          vplus;
  logic                   cnt_sat;
  logic                   in_range;
  logic [RW-1:0]          sub_a;
  logic [RW:0]            diff;
  logic                   ge;
  logic                   scan_last_attr;
  logic [KW-1:0]          k_lim;
  logic                   out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign item_addr = AW'(32'(item.attribute) * NUM_CATEGORIES + 32'(item.value));
  assign scan_addr = AW'(32'(scan_attr) * NUM_CATEGORIES + 32'(scan_cat));
  assign attr_idx  = AIW'(item.attribute);
  assign vplus     = KW'(item.value) + KW'(1);
  assign cnt_sat   = (cnt_q == COUNT_MAX);
  assign in_range  = (32'(in_data.attribute) < NUM_ATTRIBUTES) &&
                     (32'(in_data.value) < NUM_CATEGORIES);
  assign scan_last_attr = (scan_attr == AIW'(NUM_ATTRIBUTES - 1));
  assign k_lim     = (k_q > KW'(NUM_CATEGORIES)) ? KW'(NUM_CATEGORIES) : k_q;

  // shared compare/subtract: overflow check, then one quotient bit a cycle
  assign sub_a = (state == S_DIV) ? {rem[RW-2:0], 1'b0} : rem;
  assign diff  = {1'b0, sub_a} - {2'b00, den_r};
  assign ge    = !diff[RW];

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = item_addr;
    cnt_wdata = cnt_q + COUNT_WIDTH'(1);
    k_we      = 1'b0;
    k_waddr   = attr_idx;
    k_wdata   = vplus;
    cnt_raddr = (state == S_SCAN_RD) ? scan_addr : item_addr;
    k_raddr   = (state == S_SCAN_K) ? scan_attr : attr_idx;
    if (state == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
      cnt_wdata = '0;
      k_we      = (32'(clr_idx) < NUM_ATTRIBUTES);
      k_waddr   = clr_idx[AIW-1:0];
      k_wdata   = '0;
    end else if (state == S_ACC_WR) begin
      cnt_we = !cnt_sat;
      k_we   = (vplus > k_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= count_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      k_mem[k_waddr] <= k_wdata;
    end
    k_q <= k_mem[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      clr_idx          <= '0;
      clr_reply        <= 1'b0;
      instance_count   <= '0;
      smoothing_enable <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        smoothing_enable <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (clr_idx == AW'(DEPTH - 1)) begin
            clr_idx        <= '0;
            instance_count <= '0;
            state          <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_idx <= clr_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            unique case (in_data.cmd)
              CMD_CLEAR: begin
                res       <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              CMD_ACC: begin
                if (in_range) begin
                  res   <= '0;
                  state <= S_RD;
                end else begin
                  res   <= cfe_out_t'{probability: '0, zero_found: 1'b0, status: ST_RANGE};
                  state <= S_DONE;
                end
              end
              CMD_QUERY: begin
                if (!in_range) begin
                  res   <= cfe_out_t'{probability: '0, zero_found: 1'b0, status: ST_RANGE};
                  state <= S_DONE;
                end else if (instance_count == '0) begin
                  res   <= cfe_out_t'{probability: '0, zero_found: 1'b0, status: ST_EMPTY};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_RD;
                end
              end
              CMD_SCAN: begin
                res       <= '0;
                scan_attr <= '0;
                state     <= S_SCAN_K;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          state <= (item.cmd == CMD_ACC) ? S_ACC_WR : S_Q_SETUP;
        end
        S_ACC_WR: begin
          if (cnt_sat || (item.row_end && instance_count == COUNT_MAX)) begin
            res.status <= ST_SAT;
          end
          if (item.row_end && instance_count != COUNT_MAX) begin
            instance_count <= instance_count + COUNT_WIDTH'(1);
          end
          state <= S_DONE;
        end
        S_Q_SETUP: begin
          if (smoothing_enable) begin
            rem   <= RW'(DW'(cnt_q) + DW'(1));
            den_r <= DW'(instance_count) + DW'(k_q);
          end else begin
            rem   <= RW'(cnt_q);
            den_r <= DW'(instance_count);
          end
          bitcnt <= '0;
          state  <= S_DIV_CHK;
        end
        S_DIV_CHK: begin
          if (ge) begin
            res.probability <= {PROB_BITS{1'b1}};
            state           <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem             <= ge ? diff[RW-1:0] : sub_a;
          res.probability <= {res.probability[PROB_BITS-2:0], ge};
          bitcnt          <= bitcnt + BCW'(1);
          if (bitcnt == BCW'(PROB_BITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_SCAN_K: begin
          state <= S_SCAN_KW;
        end
        S_SCAN_KW: begin
          scan_lim <= k_lim;
          scan_cat <= '0;
          if (k_lim != '0) begin
            state <= S_SCAN_RD;
          end else if (scan_last_attr) begin
            state <= S_DONE;
          end else begin
            scan_attr <= scan_attr + AIW'(1);
            state     <= S_SCAN_K;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (cnt_q == '0) begin
            res.zero_found <= 1'b1;
            state          <= S_DONE;
          end else if (KW'(scan_cat) + KW'(1) != scan_lim) begin
            scan_cat <= scan_cat + CIW'(1);
            state    <= S_SCAN_RD;
          end else if (scan_last_attr) begin
            state <= S_DONE;
          end else begin
            scan_attr <= scan_attr + AIW'(1);
            state     <= S_SCAN_K;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/cfe_checker.sv
// Port-level checks for the categorical frequency estimator, bound to the top level.
module cfe_checker
  import cfe_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cfe_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken without going busy");

  a_fault_no_prob: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.probability == '0 && !out_data.zero_found)
    else $error("faulted result carries data");

  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_found |->
      out_data.probability == '0 && out_data.status == ST_OK)
    else $error("scan result carries probability or fault");

endmodule

bind categorical_frequency_estimator_unit cfe_checker u_cfe_checker (.*);

>>> sim/tb_categorical_frequency_estimator_unit.sv
// Self-checking testbench for categorical_frequency_estimator_unit with random idling and stalls.
module tb_categorical_frequency_estimator_unit;
  import cfe_pkg::*;

  localparam int ATTRS = NUM_ATTRIBUTES_DEF;
  localparam int CATS  = NUM_CATEGORIES_DEF;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cfe_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cfe_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  cfe_in_t  cmd_backlog[$];
  cfe_out_t due_results[$];
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       mismatches = 0;

  logic [COUNT_WIDTH_DEF-1:0] value_counts[ATTRS][CATS];
  logic [COUNT_WIDTH_DEF-1:0] instance_total;
  logic [4:0]                 cat_span[ATTRS];
  bit                         smooth_on = 1'b0;

  categorical_frequency_estimator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void wipe_histogram();
    for (int a = 0; a < ATTRS; a++) begin
      cat_span[a] = '0;
      for (int c = 0; c < CATS; c++) value_counts[a][c] = '0;
    end
    instance_total = '0;
  endfunction

  // attribute and value fields cannot exceed the table at these sizes
  function automatic cfe_out_t histogram_response(cfe_in_t w);
    cfe_out_t        r;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    r = '0;
    case (w.cmd)
      CMD_CLEAR: wipe_histogram();
      CMD_ACC: begin
        if (value_counts[w.attribute][w.value] == COUNT_TOP) r.status = ST_SAT;
        else value_counts[w.attribute][w.value] += 1'b1;
        if (5'(w.value) + 5'd1 > cat_span[w.attribute])
          cat_span[w.attribute] = 5'(w.value) + 5'd1;
        if (w.row_end) begin
          if (instance_total == COUNT_TOP) r.status = ST_SAT;
          else instance_total += 1'b1;
        end
      end
      CMD_QUERY: begin
        if (instance_total == '0) begin
          r.status = ST_EMPTY;
        end else begin
          num = value_counts[w.attribute][w.value];
          den = instance_total;
          if (smooth_on) begin
            num += 1;
            den += cat_span[w.attribute];
          end
          q = (num << 16) / den;
          r.probability = (q > 65535) ? 16'hFFFF : q[15:0];
        end
      end
      default: begin
        for (int a = 0; a < ATTRS; a++)
          for (int c = 0; c < CATS; c++)
            if (c < cat_span[a] && value_counts[a][c] == '0) r.zero_found = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic check_result(cfe_out_t got);
    cfe_out_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: prob %0d zero %0d status %0d",
                 got.probability, got.zero_found, got.status);
    end else begin
      want = due_results.pop_front();
      if (got.probability !== want.probability || got.zero_found !== want.zero_found ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp prob %0d zero %0d status %0d, got prob %0d zero %0d status %0d",
                   want.probability, want.zero_found, want.status,
                   got.probability, got.zero_found, got.status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(histogram_response(in_data));
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void post_word(logic [1:0] c, logic [2:0] a, logic [3:0] v, logic re);
    cmd_backlog.push_back('{cmd: c, attribute: a, value: v, row_end: re});
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic set_smoothing(bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    smooth_on = v;
    @(negedge clk);
  endtask

  // mostly whole rows of accumulates with queries, scans and occasional clears, plus raw noise
  task automatic queue_random(int n);
    int         made;
    int         pick;
    logic [3:0] vtop;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        vtop = ($urandom_range(3) == 0) ? 4'd15 : 4'($urandom_range(4, 1));
        for (int a = 0; a < ATTRS; a++)
          post_word(CMD_ACC, 3'(a), 4'($urandom_range(vtop)), a == ATTRS - 1);
        made += ATTRS;
      end else begin
        if (pick < 75)
          post_word(CMD_QUERY, 3'($urandom), 4'($urandom), 1'($urandom));
        else if (pick < 85)
          post_word(CMD_SCAN, 3'($urandom), 4'($urandom), 1'($urandom));
        else if (pick < 87)
          post_word(CMD_CLEAR, 3'($urandom), 4'($urandom), 1'($urandom));
        else
          post_word(2'($urandom), 3'($urandom), 4'($urandom), 1'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    wipe_histogram();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    post_word(CMD_QUERY, 3'd0, 4'd0, 1'b0);
    post_word(CMD_SCAN, 3'd0, 4'd0, 1'b0);
    post_word(CMD_ACC, 3'd0, 4'd0, 1'b0);
    post_word(CMD_ACC, 3'd7, 4'd15, 1'b1);
    post_word(CMD_ACC, 3'd3, 4'd5, 1'b1);
    post_word(CMD_QUERY, 3'd0, 4'd0, 1'b0);
    post_word(CMD_QUERY, 3'd7, 4'd15, 1'b0);
    post_word(CMD_QUERY, 3'd2, 4'd9, 1'b1);
    post_word(CMD_ACC, 3'd0, 4'd0, 1'b0);
    post_word(CMD_ACC, 3'd0, 4'd0, 1'b0);
    post_word(CMD_QUERY, 3'd0, 4'd0, 1'b0);
    post_word(CMD_SCAN, 3'd7, 4'd15, 1'b1);
    settle();
    set_smoothing(1'b1);
    post_word(CMD_QUERY, 3'd7, 4'd15, 1'b0);
    post_word(CMD_QUERY, 3'd1, 4'd12, 1'b0);
    post_word(CMD_QUERY, 3'd0, 4'd10, 1'b0);
    post_word(CMD_CLEAR, 3'd7, 4'd15, 1'b1);
    post_word(CMD_QUERY, 3'd0, 4'd0, 1'b0);
    post_word(CMD_SCAN, 3'd0, 4'd0, 1'b0);
    post_word(CMD_ACC, 3'd2, 4'd0, 1'b1);
    post_word(CMD_SCAN, 3'd0, 4'd0, 1'b0);
    post_word(CMD_QUERY, 3'd2, 4'd0, 1'b0);
    post_word(CMD_ACC, 3'd2, 4'd3, 1'b0);
    post_word(CMD_SCAN, 3'd0, 4'd0, 1'b0);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      set_smoothing(p[0]);
      queue_random(100);
      settle();
      queue_random(100);
      settle();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
